[rtl/core/bmtc_pkg.sv]
// Shared types and constants for the bottom/middle/top to luma/chroma converter.
// Used by every stage module and by the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bmtc_pkg;

    // Pixel channel width and chroma offset.
    localparam int CHAN_W        = 16;
    localparam int CHROMA_OFFSET = 32768;

    // Number of color channels carried side by side through the pipeline.
    localparam int LANES = 3;

    // Signed width of the widest numerator (12*Y + 3*U + 2*V and friends).
    localparam int NUM_W = 22;

    // Non-negative magnitude after the pre-shift, always below 2**18.
    localparam int MAG_W = 18;

    // Divide by three as a reciprocal multiply: q = (x * 174763) >> 19,
    // exact for every x below 2**18.
    localparam int              RECIP3_SHIFT = 19;
    localparam logic [MAG_W-1:0] RECIP3      = 18'd174763;
    localparam int              PROD_W       = 2 * MAG_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 1'd1;

    typedef enum logic {
        MATRIX_MEAN = 1'b0,
        MATRIX_TOP  = 1'b1
    } matrix_e;

    typedef enum logic {
        DIR_FWD = 1'b0,
        DIR_INV = 1'b1
    } dir_e;

    // One channel after the front stage: sign of the numerator, the
    // pre-shifted magnitude and whether it still has to be divided by three.
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic             div3;
    } lane_t;

    // One channel after the divide stage.
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] quo;
    } quot_t;

endpackage

`default_nettype wire

[rtl/core/bmtc_front.sv]
// Front stage: forms the matrix numerators for the selected mode and direction.
// Depends on bmtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmtc_front (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   valid_in,
    output logic                                        ready_out,
    input  wire logic                                   ready_in,
    input  wire logic [bmtc_pkg::CHAN_W-1:0]            chan_a,
    input  wire logic [bmtc_pkg::CHAN_W-1:0]            chan_b,
    input  wire logic [bmtc_pkg::CHAN_W-1:0]            chan_c,
    input  wire logic                                   frame_end_in,
    input  wire bmtc_pkg::matrix_e                      matrix_mode,
    input  wire bmtc_pkg::dir_e                         direction,
    output logic                                        valid_out,
    output bmtc_pkg::lane_t [bmtc_pkg::LANES-1:0]       lane_out,
    output logic                                        frame_end_out
);
    import bmtc_pkg::*;

    localparam logic signed [NUM_W-1:0] OFFSET = NUM_W'(CHROMA_OFFSET);

    logic signed [NUM_W-1:0] a_ext;
    logic signed [NUM_W-1:0] b_ext;
    logic signed [NUM_W-1:0] c_ext;
    logic signed [NUM_W-1:0] u_val;
    logic signed [NUM_W-1:0] v_val;
    logic signed [NUM_W-1:0] num     [LANES];
    logic        [1:0]       shamt   [LANES];
    logic                    div3    [LANES];
    logic signed [NUM_W-1:0] shifted [LANES];

    logic                          valid_reg;
    lane_t [LANES-1:0]             lane_reg;
    lane_t [LANES-1:0]             lane_next;
    logic                          frame_end_reg;

    assign a_ext = $signed({{(NUM_W-CHAN_W){1'b0}}, chan_a});
    assign b_ext = $signed({{(NUM_W-CHAN_W){1'b0}}, chan_b});
    assign c_ext = $signed({{(NUM_W-CHAN_W){1'b0}}, chan_c});
    assign u_val = b_ext - OFFSET;
    assign v_val = c_ext - OFFSET;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            num[i]   = '0;
            shamt[i] = 2'd0;
            div3[i]  = 1'b0;
        end
        unique case (direction)
            DIR_FWD:
            begin
                num[1] = NUM_W'(2 * a_ext - 2 * c_ext + OFFSET);
                num[2] = NUM_W'(a_ext - 2 * b_ext + c_ext + OFFSET);
                if (matrix_mode == MATRIX_MEAN)
                begin
                    num[0]  = a_ext + b_ext + c_ext;
                    div3[0] = 1'b1;
                end
                else
                begin
                    num[0] = c_ext;
                end
            end
            DIR_INV:
            begin
                if (matrix_mode == MATRIX_MEAN)
                begin
                    // Divide by twelve as a shift by two and a divide by three.
                    num[0]   = NUM_W'(12 * a_ext + 3 * u_val + 2 * v_val);
                    shamt[0] = 2'd2;
                    div3[0]  = 1'b1;
                    num[1]   = NUM_W'(3 * a_ext - v_val);
                    div3[1]  = 1'b1;
                    num[2]   = NUM_W'(12 * a_ext - 3 * u_val + 2 * v_val);
                    shamt[2] = 2'd2;
                    div3[2]  = 1'b1;
                end
                else
                begin
                    num[0]   = NUM_W'(2 * a_ext + u_val);
                    shamt[0] = 2'd1;
                    num[1]   = NUM_W'(4 * a_ext + u_val - 2 * v_val);
                    shamt[1] = 2'd2;
                    num[2]   = a_ext;
                end
            end
            default:
            begin
                num[0] = '0;
            end
        endcase
    end

    // A negative numerator truncates toward zero to a value that is at most
    // zero, so it always saturates to zero; only the sign is kept then.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            shifted[i]        = num[i] >>> shamt[i];
            lane_next[i].neg  = num[i][NUM_W-1];
            lane_next[i].mag  = num[i][NUM_W-1] ? '0 : shifted[i][MAG_W-1:0];
            lane_next[i].div3 = div3[i];
        end
    end

    assign ready_out = !valid_reg || ready_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_out && valid_in)
        begin
            lane_reg      <= lane_next;
            frame_end_reg <= frame_end_in;
        end
    end

    assign valid_out     = valid_reg;
    assign lane_out      = lane_reg;
    assign frame_end_out = frame_end_reg;

endmodule

`default_nettype wire

[rtl/core/bmtc_div.sv]
// Divide stage: exact divide by three through a reciprocal multiply per lane.
// Depends on bmtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmtc_div (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   valid_in,
    output logic                                        ready_out,
    input  wire logic                                   ready_in,
    input  wire bmtc_pkg::lane_t [bmtc_pkg::LANES-1:0]  lane_in,
    input  wire logic                                   frame_end_in,
    output logic                                        valid_out,
    output bmtc_pkg::quot_t [bmtc_pkg::LANES-1:0]       quot_out,
    output logic                                        frame_end_out
);
    import bmtc_pkg::*;

    logic [PROD_W-1:0]   prod [LANES];
    quot_t [LANES-1:0]   quot_next;
    quot_t [LANES-1:0]   quot_reg;
    logic                valid_reg;
    logic                frame_end_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            prod[i] = {{MAG_W{1'b0}}, lane_in[i].mag} * {{MAG_W{1'b0}}, RECIP3};
            quot_next[i].neg = lane_in[i].neg;
            quot_next[i].quo = lane_in[i].div3
                             ? MAG_W'(prod[i][PROD_W-1:RECIP3_SHIFT])
                             : lane_in[i].mag;
        end
    end

    assign ready_out = !valid_reg || ready_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_out && valid_in)
        begin
            quot_reg      <= quot_next;
            frame_end_reg <= frame_end_in;
        end
    end

    assign valid_out     = valid_reg;
    assign quot_out      = quot_reg;
    assign frame_end_out = frame_end_reg;

endmodule

`default_nettype wire

[rtl/core/bmtc_sat.sv]
// Output stage: saturates each lane to 0..65535 and holds the result register.
// Depends on bmtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmtc_sat (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   valid_in,
    output logic                                        ready_out,
    input  wire logic                                   stall,
    input  wire bmtc_pkg::quot_t [bmtc_pkg::LANES-1:0]  quot_in,
    input  wire logic                                   frame_end_in,
    output logic                                        valid_out,
    output logic [bmtc_pkg::CHAN_W-1:0]                 res_a,
    output logic [bmtc_pkg::CHAN_W-1:0]                 res_b,
    output logic [bmtc_pkg::CHAN_W-1:0]                 res_c,
    output logic                                        frame_end_out
);
    import bmtc_pkg::*;

    logic [CHAN_W-1:0] sat_next [LANES];
    logic [CHAN_W-1:0] res_reg  [LANES];
    logic              valid_reg;
    logic              frame_end_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (quot_in[i].neg)
                sat_next[i] = '0;
            else if (quot_in[i].quo[MAG_W-1:CHAN_W] != '0)
                sat_next[i] = '1;
            else
                sat_next[i] = quot_in[i].quo[CHAN_W-1:0];
        end
    end

    assign ready_out = !valid_reg || !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_out && valid_in)
        begin
            res_reg       <= sat_next;
            frame_end_reg <= frame_end_in;
        end
    end

    assign valid_out     = valid_reg;
    assign res_a         = res_reg[0];
    assign res_b         = res_reg[1];
    assign res_c         = res_reg[2];
    assign frame_end_out = frame_end_reg;

endmodule

`default_nettype wire

[rtl/core/bmt_yuv_color_convert_top.sv]
// Throughput: one pixel per clock while out_stall is low, through three register stages
// (numerator adders, reciprocal divide-by-three multipliers, saturation and output register).
// Each stage holds its item when the next stage cannot take it, so bubbles fill up under stall.
// Reset is asynchronous and active low; it empties the pipeline and returns
// matrix_mode and direction to zero (mean-luma matrix, forward direction).
`timescale 1ns / 1ps
`default_nettype none

module bmt_yuv_color_convert_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Configuration write port.
    input  wire logic                               cfg_we,
    input  wire logic [bmtc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bmtc_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Input pixel channel.
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [bmtc_pkg::CHAN_W-1:0]        chan_a,
    input  wire logic [bmtc_pkg::CHAN_W-1:0]        chan_b,
    input  wire logic [bmtc_pkg::CHAN_W-1:0]        chan_c,
    input  wire logic                               frame_end_in,
    // Result pixel channel.
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [bmtc_pkg::CHAN_W-1:0]             res_a,
    output logic [bmtc_pkg::CHAN_W-1:0]             res_b,
    output logic [bmtc_pkg::CHAN_W-1:0]             res_c,
    output logic                                    frame_end_out
);
    import bmtc_pkg::*;

    // Configuration registers. They are sampled as each pixel enters the
    // front stage, so a pixel is converted with the settings of its own
    // entry time.
    matrix_e matrix_mode_reg;
    dir_e    direction_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_mode_reg <= MATRIX_MEAN;
            direction_reg   <= DIR_FWD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MATRIX_MODE: matrix_mode_reg <= matrix_e'(cfg_data[0]);
                REG_DIRECTION:   direction_reg   <= dir_e'(cfg_data[0]);
                default:         ;
            endcase
        end
    end

    // Pipeline wiring. Each stage is ready when it is empty or when the
    // stage after it is ready, so the ready chain ripples back from the
    // output stall through the three stages.
    logic                  front_valid;
    logic                  front_ready;
    lane_t [LANES-1:0]     front_lane;
    logic                  front_frame_end;

    logic                  div_valid;
    logic                  div_ready;
    quot_t [LANES-1:0]     div_quot;
    logic                  div_frame_end;

    logic                  sat_ready;

    assign in_stall = !front_ready;

    bmtc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .valid_in      (in_valid),
        .ready_out     (front_ready),
        .ready_in      (div_ready),
        .chan_a        (chan_a),
        .chan_b        (chan_b),
        .chan_c        (chan_c),
        .frame_end_in  (frame_end_in),
        .matrix_mode   (matrix_mode_reg),
        .direction     (direction_reg),
        .valid_out     (front_valid),
        .lane_out      (front_lane),
        .frame_end_out (front_frame_end)
    );

    bmtc_div u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .valid_in      (front_valid),
        .ready_out     (div_ready),
        .ready_in      (sat_ready),
        .lane_in       (front_lane),
        .frame_end_in  (front_frame_end),
        .valid_out     (div_valid),
        .quot_out      (div_quot),
        .frame_end_out (div_frame_end)
    );

    bmtc_sat u_sat (
        .clk           (clk),
        .rst_n         (rst_n),
        .valid_in      (div_valid),
        .ready_out     (sat_ready),
        .stall         (out_stall),
        .quot_in       (div_quot),
        .frame_end_in  (div_frame_end),
        .valid_out     (out_valid),
        .res_a         (res_a),
        .res_b         (res_b),
        .res_c         (res_c),
        .frame_end_out (frame_end_out)
    );

endmodule

`default_nettype wire

[rtl/core/bmtc_checker.sv]
// Port-level checker for the converter and the bind that attaches it to the top level.
// Depends on bmtc_pkg and bmt_yuv_color_convert_top.
`timescale 1ns / 1ps
`default_nettype none

module bmtc_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_stall,
    input  wire logic                               out_valid,
    input  wire logic                               out_stall,
    input  wire logic [bmtc_pkg::CHAN_W-1:0]        res_a,
    input  wire logic [bmtc_pkg::CHAN_W-1:0]        res_b,
    input  wire logic [bmtc_pkg::CHAN_W-1:0]        res_c,
    input  wire logic                               frame_end_out
);
    // A stalled result transaction stays valid and keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(res_a) && $stable(res_b)
                                   && $stable(res_c) && $stable(frame_end_out))
        else $error("stalled result transaction changed");

    // The input is only held off when every stage is full behind a stalled output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // An accepted pixel reaches the output through the front, divide and output registers when not stalled.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("pixel did not reach the output in three cycles");

endmodule

bind bmt_yuv_color_convert_top bmtc_checker u_bmtc_checker (.*);

`default_nettype wire

[tb/bmt_yuv_color_checker.sv]
// Passive checker for the bottom/middle/top to luma/chroma converter.
// Tracks register writes, predicts each result transaction and compares it in order.
// Depends on bmtc_pkg for the channel width, register indexes and mode enums.
`timescale 1ns / 1ps

module bmt_yuv_color_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bmtc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bmtc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [bmtc_pkg::CHAN_W-1:0]       chan_a,
    input  logic [bmtc_pkg::CHAN_W-1:0]       chan_b,
    input  logic [bmtc_pkg::CHAN_W-1:0]       chan_c,
    input  logic                              frame_end_in,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [bmtc_pkg::CHAN_W-1:0]       res_a,
    input  logic [bmtc_pkg::CHAN_W-1:0]       res_b,
    input  logic [bmtc_pkg::CHAN_W-1:0]       res_c,
    input  logic                              frame_end_out,
    output int                                mismatches,
    output int                                pixels_in_flight
);
    import bmtc_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] c;
        logic              frame_end;
    } pixel_t;

    matrix_e matrix_sel;
    dir_e    dir_sel;
    pixel_t  converted_q[$];

    function automatic logic [CHAN_W-1:0] clamp16(int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return '1;
        return v[CHAN_W-1:0];
    endfunction

    // Integer conversion; SystemVerilog division truncates toward zero.
    function automatic pixel_t convert_pixel(matrix_e m, dir_e d, pixel_t p);
        int     x;
        int     y;
        int     z;
        int     u;
        int     v;
        int     r0;
        int     r1;
        int     r2;
        pixel_t q;
        x = p.a;
        y = p.b;
        z = p.c;
        if (d == DIR_FWD)
        begin
            u  = 2 * x - 2 * z;
            v  = x - 2 * y + z;
            r0 = (m == MATRIX_MEAN) ? (x + y + z) / 3 : z;
            r1 = u + CHROMA_OFFSET;
            r2 = v + CHROMA_OFFSET;
        end
        else
        begin
            u = y - CHROMA_OFFSET;
            v = z - CHROMA_OFFSET;
            if (m == MATRIX_MEAN)
            begin
                r0 = (12 * x + 3 * u + 2 * v) / 12;
                r1 = (3 * x - v) / 3;
                r2 = (12 * x - 3 * u + 2 * v) / 12;
            end
            else
            begin
                r0 = (2 * x + u) / 2;
                r1 = (4 * x + u - 2 * v) / 4;
                r2 = x;
            end
        end
        q.a         = clamp16(r0);
        q.b         = clamp16(r1);
        q.c         = clamp16(r2);
        q.frame_end = p.frame_end;
        return q;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t got;
        pixel_t want;
        if (!rst_n)
        begin
            matrix_sel = MATRIX_MEAN;
            dir_sel    = DIR_FWD;
            converted_q.delete();
            mismatches       <= 0;
            pixels_in_flight <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                converted_q.push_back(convert_pixel(matrix_sel, dir_sel,
                                      {chan_a, chan_b, chan_c, frame_end_in}));
            if (out_valid && !out_stall)
            begin
                got = {res_a, res_b, res_c, frame_end_out};
                if (converted_q.size() == 0)
                begin
                    $error("result transaction with no pixel outstanding");
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = converted_q.pop_front();
                    if (got != want)
                        mismatches <= mismatches + 1;
                    if (got.a != want.a)
                        $error("res_a: expected %0d, actual %0d", want.a, got.a);
                    if (got.b != want.b)
                        $error("res_b: expected %0d, actual %0d", want.b, got.b);
                    if (got.c != want.c)
                        $error("res_c: expected %0d, actual %0d", want.c, got.c);
                    if (got.frame_end != want.frame_end)
                        $error("frame_end_out: expected %0d, actual %0d",
                               want.frame_end, got.frame_end);
                end
            end
            // Register writes take effect for pixels accepted after this edge.
            if (cfg_we)
            begin
                if (cfg_index == REG_MATRIX_MODE)
                    matrix_sel = matrix_e'(cfg_data[0]);
                else if (cfg_index == REG_DIRECTION)
                    dir_sel = dir_e'(cfg_data[0]);
            end
            pixels_in_flight <= converted_q.size();
        end
    end

endmodule

[tb/tb_bmt_yuv_color_convert_top.sv]
// Top-level testbench for bmt_yuv_color_convert_top: clock, reset, stimulus and verdict.
// Depends on bmtc_pkg, the converter RTL and the bmt_yuv_color_checker module.
`timescale 1ns / 1ps

module tb_bmt_yuv_color_convert_top;
    import bmtc_pkg::*;

    // Pipeline depth from an accepted input transaction to out_valid.
    localparam int PIPE_LATENCY   = 3;
    // Items in the random part, split evenly over the configuration phases.
    localparam int RANDOM_PIXELS  = 850;
    localparam int PHASES         = 10;
    // Length of the long receiver hold-off, and how many back-to-back
    // pixels the sender offers against it.
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_BURST     = 40;
    localparam int DRAIN_LIMIT    = 100000;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [CHAN_W-1:0]       chan_a;
    logic [CHAN_W-1:0]       chan_b;
    logic [CHAN_W-1:0]       chan_c;
    logic                    frame_end_in;
    logic                    out_valid;
    logic                    out_stall;
    logic [CHAN_W-1:0]       res_a;
    logic [CHAN_W-1:0]       res_b;
    logic [CHAN_W-1:0]       res_c;
    logic                    frame_end_out;

    int mismatches;
    int pixels_in_flight;

    // Handshake between the stimulus process and the receiver process for
    // the long hold-off: the sender raises the request, the receiver flags
    // when the hold-off has actually begun.
    bit hold_request;
    bit hold_active;

    bmt_yuv_color_convert_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .chan_a        (chan_a),
        .chan_b        (chan_b),
        .chan_c        (chan_c),
        .frame_end_in  (frame_end_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .res_a         (res_a),
        .res_b         (res_b),
        .res_c         (res_c),
        .frame_end_out (frame_end_out)
    );

    // The checker sits beside the block and sees exactly what the block sees.
    bmt_yuv_color_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .chan_a           (chan_a),
        .chan_b           (chan_b),
        .chan_c           (chan_c),
        .frame_end_in     (frame_end_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .res_a            (res_a),
        .res_b            (res_b),
        .res_c            (res_c),
        .frame_end_out    (frame_end_out),
        .mismatches       (mismatches),
        .pixels_in_flight (pixels_in_flight)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    // Channel values: uniform half of the time, otherwise a corner value or a
    // value close to a reference channel. Nearby channels keep the chroma
    // small, so not every result sits at a saturation rail.
    function automatic logic [CHAN_W-1:0] pick_channel(logic [CHAN_W-1:0] near);
        int r;
        int s;
        r = $urandom_range(0, 9);
        if (r < 5)
            return CHAN_W'($urandom());
        if (r < 7)
        begin
            case ($urandom_range(0, 5))
                0: return 16'd0;
                1: return 16'd1;
                2: return 16'd32767;
                3: return 16'd32768;
                4: return 16'd65534;
                default: return 16'd65535;
            endcase
        end
        s = int'(near) + $urandom_range(0, 1200) - 600;
        return s[CHAN_W-1:0];
    endfunction

    // Offers one pixel transaction and returns in the time step in which it
    // was accepted. in_stall is read right after the edge, so it is the value
    // the block saw at that edge. Unless eager, a random idle gap follows.
    task automatic send_pixel(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b,
                              input logic [CHAN_W-1:0] c, input logic fe,
                              input bit eager);
        int gap;
        chan_a       <= a;
        chan_b       <= b;
        chan_c       <= c;
        frame_end_in <= fe;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        gap = eager ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering and waits until every predicted pixel has come back,
    // then lets the pipeline settle. Returns 0 if it never empties.
    task automatic drain(output bit emptied);
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (pixels_in_flight != 0 && waited < DRAIN_LIMIT);
        emptied = (pixels_in_flight == 0);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // One register write per clock; the caller lowers cfg_we afterwards.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_mode(input matrix_e m, input dir_e d);
        write_reg(REG_MATRIX_MODE, CFG_DATA_W'(m));
        write_reg(REG_DIRECTION, CFG_DATA_W'(d));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Corner pixels for one direction: all-zero and all-ones, chroma driven
    // past both rails, and in the inverse direction small negative quotients
    // that must truncate toward zero before saturation.
    task automatic run_directed(input dir_e d);
        logic [CHAN_W-1:0] fwd_set [6][3] = '{
            '{16'd0,     16'd0,     16'd0},
            '{16'd65535, 16'd65535, 16'd65535},
            '{16'd65535, 16'd0,     16'd0},
            '{16'd0,     16'd0,     16'd65535},
            '{16'd0,     16'd65535, 16'd0},
            '{16'd65535, 16'd0,     16'd65535}
        };
        logic [CHAN_W-1:0] inv_set [6][3] = '{
            '{16'd0,     16'd0,     16'd0},
            '{16'd65535, 16'd65535, 16'd65535},
            '{16'd0,     16'd32769, 16'd32768},
            '{16'd0,     16'd32768, 16'd32769},
            '{16'd65535, 16'd0,     16'd0},
            '{16'd1000,  16'd65535, 16'd0}
        };
        for (int k = 0; k < 6; k++)
        begin
            if (d == DIR_FWD)
                send_pixel(fwd_set[k][0], fwd_set[k][1], fwd_set[k][2],
                           k == 2 || k == 5, 1'b0);
            else
                send_pixel(inv_set[k][0], inv_set[k][1], inv_set[k][2],
                           k == 2 || k == 5, 1'b0);
        end
    endtask

    // Receiver: drives out_stall once per clock from a few counters. Short
    // random stalls alternate with free stretches, some of them long, and a
    // requested hold-off overrides everything until its counter runs out.
    initial
    begin
        int hold_left;
        int busy_left;
        int free_left;
        hold_left   = 0;
        busy_left   = 0;
        free_left   = 0;
        hold_active = 1'b0;
        out_stall   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                hold_active  = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
                if (hold_left == 0)
                    hold_active = 1'b0;
            end
            else if (busy_left > 0)
            begin
                busy_left--;
                out_stall <= 1'b1;
            end
            else if (free_left > 0)
            begin
                free_left--;
                out_stall <= 1'b0;
            end
            else
            begin
                busy_left = gap_len();
                free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                          : $urandom_range(1, 12);
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus: reset, directed corners in every mode, then random phases
    // each with its own register setting, draining between phases.
    initial
    begin
        bit                emptied;
        bit                all_emptied;
        bit                eager;
        matrix_e           m;
        dir_e              d;
        logic [CHAN_W-1:0] a;
        int                per_phase;
        all_emptied  = 1'b1;
        hold_request = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        chan_a       = '0;
        chan_b       = '0;
        chan_c       = '0;
        frame_end_in = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: the first set runs on the reset setting, then all
        // four register combinations are written explicitly.
        run_directed(DIR_FWD);
        for (int k = 0; k < 4; k++)
        begin
            drain(emptied);
            all_emptied &= emptied;
            set_mode(matrix_e'(k[0]), dir_e'(k[1]));
            if (k > 0)
                run_directed(dir_e'(k[1]));
        end

        // Random part. The first four phases walk through every setting, the
        // rest choose one at random. Two phases start with the long receiver
        // hold-off while the sender keeps pushing, so the pipeline backs up
        // and in_stall has to rise.
        per_phase = RANDOM_PIXELS / PHASES;
        for (int p = 0; p < PHASES; p++)
        begin
            drain(emptied);
            all_emptied &= emptied;
            if (p < 4)
            begin
                m = matrix_e'(p[0]);
                d = dir_e'(p[1]);
            end
            else
            begin
                m = matrix_e'($urandom_range(0, 1));
                d = dir_e'($urandom_range(0, 1));
            end
            set_mode(m, d);
            if (p == 1 || p == 6)
            begin
                hold_request = 1'b1;
                while (!hold_active)
                    @(posedge clk);
            end
            eager = 1'b1;
            for (int i = 0; i < per_phase; i++)
            begin
                // After the burst against a hold-off, gap style changes in
                // blocks so there are stretches with and without idling.
                if (i >= HOLD_BURST && i % 20 == 0)
                    eager = ($urandom_range(0, 2) == 0);
                else if (i % 20 == 0 && p != 1 && p != 6)
                    eager = ($urandom_range(0, 2) == 0);
                a = CHAN_W'($urandom());
                send_pixel(a, pick_channel(a), pick_channel(a),
                           $urandom_range(0, 15) == 0, eager);
            end
        end

        drain(emptied);
        all_emptied &= emptied;

        if (mismatches == 0 && all_emptied)
            $display("tb_bmt_yuv_color_convert_top: PASS");
        else
            $display("tb_bmt_yuv_color_convert_top: FAIL");
        $finish;
    end

    // Watchdog: ends a run that hangs on a handshake.
    initial
    begin
        #10_000_000;
        $display("tb_bmt_yuv_color_convert_top: FAIL");
        $finish;
    end

endmodule
